>>> design/cfr_pkg.sv
`timescale 1ns / 1ps

package cfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;
    localparam logic [7:0] ADDR_BOUND = 8'hF1;

    localparam int LENGTH_LIMIT_DEF = 50;
    localparam int CAPTURED_BYTES   = 25;
    localparam int WORD_COUNT       = 12;

    // capture store split into even and odd byte banks
    localparam int BANK_DEPTH  = (CAPTURED_BYTES + 1) / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int STORE_SLOTS = 2 * BANK_DEPTH;
    localparam int SLOT_AW     = $clog2(STORE_SLOTS);

    localparam logic [7:0] NODE_ID_RST = 8'd1;

    localparam logic [BANK_AW-1:0] MODE_SLOT = BANK_AW'(WORD_COUNT);

endpackage

>>> design/cfr_ram.sv
`timescale 1ns / 1ps

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/uart_command_frame_receiver.sv
`timescale 1ns / 1ps

// channel   valid          ready          payload
// rx in     i_valid        o_ready        i_rx_byte
// cfg in    i_cfg_valid    o_cfg_ready    i_node_id
// field out o_valid        i_ready        o_field_index, o_field_value, o_last_field
//
// one rx byte per cycle when o_ready; parse state in flops, payload bytes in two srams
// a good frame yields 13 items; a read issues only once the previous one is in the output
// while a burst is being read, payload and checksum bytes stall; header, address,
// length and dropped bytes flow
// synchronous active-low reset; capture store reads as zero until written (valid bits)

module uart_command_frame_receiver #(
    parameter int LENGTH_LIMIT = cfr_pkg::LENGTH_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_node_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_field_index,
    output logic signed [15:0] o_field_value,
    output logic        o_last_field
);

    import cfr_pkg::*;

    localparam int LEN_W = $clog2(LENGTH_LIMIT);
    localparam logic [7:0] LIMIT_B = 8'(LENGTH_LIMIT);
    localparam logic [LEN_W-1:0] CAP_N = LEN_W'(CAPTURED_BYTES);

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_HDR2    = 6'b000100,
        PH_ADDR    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [LEN_W-1:0]    r_left, n_left;
    logic [LEN_W-1:0]    r_taken, n_taken;
    logic [7:0]          r_sum, n_sum;
    logic [7:0]          r_addr, n_addr;
    logic [7:0]          r_node_id;
    logic [STORE_SLOTS-1:0] r_vld;

    logic                r_emit_act;
    logic [BANK_AW-1:0]  r_emit_idx;
    logic                r_pend;
    logic [BANK_AW-1:0]  r_pend_idx;
    logic                r_pend_ve, r_pend_vo;

    logic                r_o_valid;
    logic [3:0]          r_o_idx;
    logic [15:0]         r_o_val;
    logic                r_o_last;

    logic                in_acc, wr_phase, mem_we, frame_good, issue;
    logic [7:0]          rd_even, rd_odd, byte_e, byte_o;
    logic [BANK_AW-1:0]  wr_bank_addr;
    logic [SLOT_AW-1:0]  wr_slot;

    assign wr_phase = ((r_phase == PH_PAYLOAD) && (r_left != '0)) || (r_phase == PH_CHECK);
    assign o_ready  = !(r_emit_act && wr_phase);
    assign in_acc   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign wr_bank_addr = r_taken[BANK_AW:1];
    assign wr_slot      = r_taken[SLOT_AW-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_taken    = r_taken;
        n_sum      = r_sum;
        n_addr     = r_addr;
        mem_we     = 1'b0;
        frame_good = 1'b0;
        if (in_acc) begin
            priority if (r_phase == PH_IDLE && i_rx_byte == HDR_FIRST) begin
                n_phase = PH_HDR1;
                n_sum   = i_rx_byte;
            end else if (r_phase == PH_HDR1 && i_rx_byte == HDR_SECOND) begin
                n_phase = PH_HDR2;
                n_sum   = r_sum + i_rx_byte;
            end else if (r_phase == PH_HDR2 && i_rx_byte != 8'd0
                         && i_rx_byte < ADDR_BOUND) begin
                n_phase = PH_ADDR;
                n_addr  = i_rx_byte;
                n_sum   = r_sum + i_rx_byte;
            end else if (r_phase == PH_ADDR && i_rx_byte < LIMIT_B) begin
                n_phase = PH_PAYLOAD;
                n_left  = i_rx_byte[LEN_W-1:0];
                n_taken = '0;
                n_sum   = r_sum + i_rx_byte;
            end else if (r_phase == PH_PAYLOAD && r_left != '0) begin
                n_left  = r_left - 1'b1;
                n_taken = r_taken + 1'b1;
                n_sum   = r_sum + i_rx_byte;
                mem_we  = (r_taken < CAP_N);
                if (r_left == LEN_W'(1)) begin
                    n_phase = PH_CHECK;
                end
            end else if (r_phase == PH_CHECK) begin
                n_phase    = PH_IDLE;
                mem_we     = (r_taken < CAP_N);
                frame_good = (i_rx_byte == r_sum) && (r_addr == r_node_id);
            end else begin
                n_phase = PH_IDLE;
            end
        end
    end

    assign issue = r_emit_act && !r_pend && (!r_o_valid || i_ready);

    cfr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (mem_we && !r_taken[0]),
        .i_waddr (wr_bank_addr),
        .i_wdata (i_rx_byte),
        .i_re    (issue),
        .i_raddr (r_emit_idx),
        .o_rdata (rd_even)
    );

    cfr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (mem_we && r_taken[0]),
        .i_waddr (wr_bank_addr),
        .i_wdata (i_rx_byte),
        .i_re    (issue),
        .i_raddr (r_emit_idx),
        .o_rdata (rd_odd)
    );

    assign byte_e = r_pend_ve ? rd_even : 8'h00;
    assign byte_o = r_pend_vo ? rd_odd  : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_left     <= '0;
            r_taken    <= '0;
            r_sum      <= '0;
            r_addr     <= '0;
            r_node_id  <= NODE_ID_RST;
            r_vld      <= '0;
            r_emit_act <= 1'b0;
            r_emit_idx <= '0;
            r_pend     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_taken <= n_taken;
            r_sum   <= n_sum;
            r_addr  <= n_addr;
            if (i_cfg_valid) begin
                r_node_id <= i_node_id;
            end
            if (mem_we) begin
                r_vld[wr_slot] <= 1'b1;
            end
            if (frame_good) begin
                r_emit_act <= 1'b1;
                r_emit_idx <= '0;
            end else if (issue) begin
                r_emit_idx <= r_emit_idx + 1'b1;
                if (r_emit_idx == MODE_SLOT) begin
                    r_emit_act <= 1'b0;
                end
            end
            r_pend <= issue;
            if (r_pend) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_idx <= r_emit_idx;
            r_pend_ve  <= r_vld[{r_emit_idx, 1'b0}];
            r_pend_vo  <= r_vld[{r_emit_idx, 1'b1}];
        end
        if (r_pend) begin
            r_o_idx  <= 4'(r_pend_idx);
            r_o_last <= (r_pend_idx == MODE_SLOT);
            r_o_val  <= (r_pend_idx == MODE_SLOT) ? {8'h00, byte_e} : {byte_e, byte_o};
        end
    end

    assign o_valid       = r_o_valid;
    assign o_field_index = r_o_idx;
    assign o_field_value = r_o_val;
    assign o_last_field  = r_o_last;

`ifndef SYNTHESIS
    a_no_write_during_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_act |-> !mem_we)
        else $error("capture store written while a burst is being read");

    a_pend_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_o_valid)
        else $error("read data not loaded into output register");

    a_pend_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (!r_o_valid || i_ready))
        else $error("read data returns while output register is held");

    a_last_is_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_field) |-> (r_o_idx == 4'(MODE_SLOT)))
        else $error("last item out of place in burst");
`endif

endmodule
